// ----- hdl/tsts_pkg.sv -----
`default_nettype none

package tsts_pkg;

   // width of the operation selector and of the result status
   localparam int OP_BITS     = 3;
   localparam int STATUS_BITS = 2;

   // operation selector carried on req_tuser
   typedef enum logic [OP_BITS-1:0] {
      OP_APPEND    = 3'd0,
      OP_CLEAR     = 3'd1,
      OP_EXACT     = 3'd2,
      OP_NEXT      = 3'd3,
      OP_PREV      = 3'd4,
      OP_RANGE_MAX = 3'd5,
      OP_RANGE_MIN = 3'd6,
      OP_NOP       = 3'd7
   } op_type;

   // result status carried on rsp_tuser
   typedef enum logic [STATUS_BITS-1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2,
      ST_EMPTY     = 2'd3
   } status_type;

   // flags from the shared compare unit
   typedef struct packed {
      logic t_eq;      // sample time equals key a
      logic t_lt_a;    // sample time earlier than key a
      logic t_gt_a;    // sample time later than key a
      logic t_gt_b;    // sample time later than key b
      logic p_better;  // new price strictly beats best price
   } cmp_res_type;

endpackage : tsts_pkg

`default_nettype wire

// ----- hdl/time_sorted_tick_store_search.sv -----
`default_nettype none

// Append-only store of (timestamp, price) ticks with timestamp search and range
// extremes. One item is taken at a time: req_tready is high only while the block
// is idle, and a finished result waits in the output register without blocking
// the next item. Append also updates the running price extremes; exact, next and
// previous searches bisect the store, reading the neighbor entry when a next or
// previous probe may be the boundary; at 4096 entries a search makes at most 13
// probes. Range max and min walk the store from index 0 one entry a cycle. The
// pace is set by the single read port of the store, whose read data is registered,
// and by the one compare unit that every compare goes through.
module time_sorted_tick_store_search
   import tsts_pkg::*;
   #(parameter int STORE_DEPTH = 4096,
     parameter int TIME_BITS   = 48,
     parameter int PRICE_BITS  = 32,
     localparam int IDXW    = $clog2(STORE_DEPTH),
     localparam int CNTW    = $clog2(STORE_DEPTH + 1),
     localparam int REQ_BITS = 2 * TIME_BITS + PRICE_BITS,
     localparam int REQ_W   = ((REQ_BITS + 7) / 8) * 8,
     localparam int RSP_BITS = IDXW + CNTW + 3 * TIME_BITS + 3 * PRICE_BITS,
     localparam int RSP_W   = ((RSP_BITS + 7) / 8) * 8)
   (input  wire                    clock,
    input  wire                    reset,
    input  wire                    req_tvalid,
    output logic                   req_tready,
    // time_a, time_b, tick_price
    input  wire  [REQ_W-1:0]       req_tdata,
    // opcode
    input  wire  [OP_BITS-1:0]     req_tuser,
    output logic                   rsp_tvalid,
    input  wire                    rsp_tready,
    // hit_index, hit_time, hit_price, entry_count, low_price, low_time,
    // high_price, high_time
    output logic [RSP_W-1:0]       rsp_tdata,
    // status
    output logic [STATUS_BITS-1:0] rsp_tuser);

   typedef enum logic [7:0] {
      S_IDLE     = 8'b0000_0001,
      S_DECODE   = 8'b0000_0010,
      S_APP_MAX  = 8'b0000_0100,
      S_BIS_ADDR = 8'b0000_1000,
      S_BIS_DATA = 8'b0001_0000,
      S_NB_DATA  = 8'b0010_0000,
      S_SCAN     = 8'b0100_0000,
      S_EMIT     = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   // captured item
   op_type                       op_ff, op_in;
   logic        [TIME_BITS-1:0]  ta_ff, ta_in;
   logic        [TIME_BITS-1:0]  tb_ff, tb_in;
   logic signed [PRICE_BITS-1:0] pr_ff, pr_in;

   // store state and running extremes
   logic        [CNTW-1:0]       count_ff, count_in;
   logic signed [PRICE_BITS-1:0] min_p_ff, min_p_in;
   logic        [TIME_BITS-1:0]  min_t_ff, min_t_in;
   logic signed [PRICE_BITS-1:0] max_p_ff, max_p_in;
   logic        [TIME_BITS-1:0]  max_t_ff, max_t_in;

   // bisection bounds [lo, hi_ex) and probe index, also scan bookkeeping
   logic        [CNTW-1:0]       lo_ff, lo_in;
   logic        [CNTW-1:0]       hi_ex_ff, hi_ex_in;
   logic        [IDXW-1:0]       mid_ff, mid_in;
   logic        [CNTW-1:0]       idx_ff, idx_in;
   logic                         pend_ff, pend_in;
   logic                         best_valid_ff, best_valid_in;
   logic        [TIME_BITS-1:0]  cand_t_ff, cand_t_in;
   logic signed [PRICE_BITS-1:0] cand_p_ff, cand_p_in;

   // working result
   status_type                   res_status_ff, res_status_in;
   logic        [IDXW-1:0]       res_idx_ff, res_idx_in;
   logic        [TIME_BITS-1:0]  res_t_ff, res_t_in;
   logic signed [PRICE_BITS-1:0] res_p_ff, res_p_in;

   // output register
   logic                         rsp_valid_ff, rsp_valid_in;
   status_type                   rsp_status_ff, rsp_status_in;
   logic        [IDXW-1:0]       rsp_idx_ff, rsp_idx_in;
   logic        [TIME_BITS-1:0]  rsp_t_ff, rsp_t_in;
   logic signed [PRICE_BITS-1:0] rsp_p_ff, rsp_p_in;
   logic        [CNTW-1:0]       rsp_cnt_ff, rsp_cnt_in;
   logic signed [PRICE_BITS-1:0] rsp_lp_ff, rsp_lp_in;
   logic        [TIME_BITS-1:0]  rsp_lt_ff, rsp_lt_in;
   logic signed [PRICE_BITS-1:0] rsp_hp_ff, rsp_hp_in;
   logic        [TIME_BITS-1:0]  rsp_ht_ff, rsp_ht_in;

   // store and compare unit hookup
   logic                         wr_en;
   logic        [IDXW-1:0]       rd_addr;
   logic        [TIME_BITS-1:0]  rd_time;
   logic signed [PRICE_BITS-1:0] rd_price;
   logic signed [PRICE_BITS-1:0] cmp_new;
   logic signed [PRICE_BITS-1:0] cmp_best;
   logic                         cmp_max;
   cmp_res_type                  cmp;

   logic        [CNTW:0]         mid_sum;
   logic        [IDXW-1:0]       mid_comb;
   logic                         store_full;
   logic                         store_empty;
   logic                         mid_is_last;
   logic                         scan_stop;

   tsts_store #(
      .DEPTH      (STORE_DEPTH),
      .IDXW       (IDXW),
      .TIME_BITS  (TIME_BITS),
      .PRICE_BITS (PRICE_BITS)
   ) u_store (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_addr  (count_ff[IDXW-1:0]),
      .wr_time  (ta_ff),
      .wr_price (pr_ff),
      .rd_addr  (rd_addr),
      .rd_time  (rd_time),
      .rd_price (rd_price)
   );

   tsts_cmp #(
      .TIME_BITS  (TIME_BITS),
      .PRICE_BITS (PRICE_BITS)
   ) u_cmp (
      .sample_time (rd_time),
      .key_a       (ta_ff),
      .key_b       (tb_ff),
      .new_price   (cmp_new),
      .best_price  (cmp_best),
      .want_max    (cmp_max),
      .res         (cmp)
   );

   // midpoint of [lo, hi_ex - 1]
   assign mid_sum     = (CNTW+1)'(lo_ff) + (CNTW+1)'(hi_ex_ff) - (CNTW+1)'(1);
   assign mid_comb    = mid_sum[IDXW:1];
   assign store_full  = (count_ff == CNTW'(STORE_DEPTH));
   assign store_empty = (count_ff == '0);
   assign mid_is_last = ((CNTW'(mid_ff) + CNTW'(1)) == count_ff);

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = RSP_W'({rsp_ht_ff, rsp_hp_ff, rsp_lt_ff, rsp_lp_ff,
                               rsp_cnt_ff, rsp_p_ff, rsp_t_ff, rsp_idx_ff});

   // read address and compare operands per step
   always_comb begin
      rd_addr  = mid_comb;
      cmp_new  = pr_ff;
      cmp_best = min_p_ff;
      cmp_max  = 1'b0;
      case (state_ff)
         S_BIS_DATA: begin
            rd_addr = (op_ff == OP_NEXT) ? (mid_ff - IDXW'(1)) : (mid_ff + IDXW'(1));
         end
         S_APP_MAX: begin
            cmp_best = max_p_ff;
            cmp_max  = 1'b1;
         end
         S_SCAN: begin
            rd_addr  = idx_ff[IDXW-1:0];
            cmp_new  = rd_price;
            cmp_best = res_p_ff;
            cmp_max  = (op_ff == OP_RANGE_MAX);
         end
         default: begin
            rd_addr = mid_comb;
         end
      endcase
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      ta_in         = ta_ff;
      tb_in         = tb_ff;
      pr_in         = pr_ff;
      count_in      = count_ff;
      min_p_in      = min_p_ff;
      min_t_in      = min_t_ff;
      max_p_in      = max_p_ff;
      max_t_in      = max_t_ff;
      lo_in         = lo_ff;
      hi_ex_in      = hi_ex_ff;
      mid_in        = mid_ff;
      idx_in        = idx_ff;
      pend_in       = pend_ff;
      best_valid_in = best_valid_ff;
      cand_t_in     = cand_t_ff;
      cand_p_in     = cand_p_ff;
      res_status_in = res_status_ff;
      res_idx_in    = res_idx_ff;
      res_t_in      = res_t_ff;
      res_p_in      = res_p_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_idx_in    = rsp_idx_ff;
      rsp_t_in      = rsp_t_ff;
      rsp_p_in      = rsp_p_ff;
      rsp_cnt_in    = rsp_cnt_ff;
      rsp_lp_in     = rsp_lp_ff;
      rsp_lt_in     = rsp_lt_ff;
      rsp_hp_in     = rsp_hp_ff;
      rsp_ht_in     = rsp_ht_ff;
      wr_en         = 1'b0;
      scan_stop     = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               op_in    = op_type'(req_tuser);
               ta_in    = req_tdata[TIME_BITS-1:0];
               tb_in    = req_tdata[2*TIME_BITS-1:TIME_BITS];
               pr_in    = req_tdata[REQ_BITS-1:2*TIME_BITS];
               state_in = S_DECODE;
            end
         end

         S_DECODE: begin
            res_status_in = ST_OK;
            res_idx_in    = '0;
            res_t_in      = '0;
            res_p_in      = '0;
            best_valid_in = 1'b0;
            lo_in         = '0;
            hi_ex_in      = count_ff;
            idx_in        = '0;
            pend_in       = 1'b0;
            state_in      = S_EMIT;
            case (op_ff)
               OP_APPEND: begin
                  if (store_full) begin
                     res_status_in = ST_FULL;
                  end else begin
                     wr_en      = 1'b1;
                     res_idx_in = count_ff[IDXW-1:0];
                     res_t_in   = ta_ff;
                     res_p_in   = pr_ff;
                     count_in   = count_ff + CNTW'(1);
                     if (store_empty) begin
                        min_p_in = pr_ff;
                        min_t_in = ta_ff;
                        max_p_in = pr_ff;
                        max_t_in = ta_ff;
                     end else begin
                        if (cmp.p_better) begin
                           min_p_in = pr_ff;
                           min_t_in = ta_ff;
                        end
                        state_in = S_APP_MAX;
                     end
                  end
               end
               OP_CLEAR: begin
                  count_in = '0;
                  min_p_in = '0;
                  min_t_in = '0;
                  max_p_in = '0;
                  max_t_in = '0;
               end
               OP_EXACT, OP_NEXT, OP_PREV: begin
                  if (store_empty) res_status_in = ST_EMPTY;
                  else state_in = S_BIS_ADDR;
               end
               OP_RANGE_MAX, OP_RANGE_MIN: begin
                  if (store_empty) res_status_in = ST_EMPTY;
                  else state_in = S_SCAN;
               end
               default: begin
                  state_in = S_EMIT;
               end
            endcase
         end

         // second price compare of an append
         S_APP_MAX: begin
            if (cmp.p_better) begin
               max_p_in = pr_ff;
               max_t_in = ta_ff;
            end
            state_in = S_EMIT;
         end

         // issue probe at the midpoint, or give up on an empty interval
         S_BIS_ADDR: begin
            if (hi_ex_ff > lo_ff) begin
               mid_in   = mid_comb;
               state_in = S_BIS_DATA;
            end else begin
               res_status_in = ST_NOT_FOUND;
               state_in      = S_EMIT;
            end
         end

         // probe data back; neighbor read issued here when needed
         S_BIS_DATA: begin
            state_in = S_BIS_ADDR;
            case (op_ff)
               OP_NEXT: begin
                  if (!cmp.t_lt_a) begin
                     if (mid_ff == '0) begin
                        res_idx_in = mid_ff;
                        res_t_in   = rd_time;
                        res_p_in   = rd_price;
                        state_in   = S_EMIT;
                     end else begin
                        cand_t_in = rd_time;
                        cand_p_in = rd_price;
                        state_in  = S_NB_DATA;
                     end
                  end else begin
                     lo_in = CNTW'(mid_ff) + CNTW'(1);
                  end
               end
               OP_PREV: begin
                  if (!cmp.t_gt_a) begin
                     if (mid_is_last) begin
                        res_idx_in = mid_ff;
                        res_t_in   = rd_time;
                        res_p_in   = rd_price;
                        state_in   = S_EMIT;
                     end else begin
                        cand_t_in = rd_time;
                        cand_p_in = rd_price;
                        state_in  = S_NB_DATA;
                     end
                  end else begin
                     hi_ex_in = CNTW'(mid_ff);
                  end
               end
               default: begin
                  // exact match
                  if (cmp.t_eq) begin
                     res_idx_in = mid_ff;
                     res_t_in   = rd_time;
                     res_p_in   = rd_price;
                     state_in   = S_EMIT;
                  end else if (cmp.t_gt_a) begin
                     hi_ex_in = CNTW'(mid_ff);
                  end else begin
                     lo_in = CNTW'(mid_ff) + CNTW'(1);
                  end
               end
            endcase
         end

         // neighbor decides whether the probe is the boundary entry
         S_NB_DATA: begin
            state_in = S_BIS_ADDR;
            if ((op_ff == OP_NEXT) ? cmp.t_lt_a : cmp.t_gt_a) begin
               res_idx_in = mid_ff;
               res_t_in   = cand_t_ff;
               res_p_in   = cand_p_ff;
               state_in   = S_EMIT;
            end else if (op_ff == OP_NEXT) begin
               hi_ex_in = CNTW'(mid_ff);
            end else begin
               lo_in = CNTW'(mid_ff) + CNTW'(1);
            end
         end

         // one entry a cycle: read idx, evaluate the entry read last cycle
         S_SCAN: begin
            if (pend_ff) begin
               if (cmp.t_lt_a) begin
                  scan_stop = 1'b0;
               end else if (cmp.t_gt_b) begin
                  scan_stop = 1'b1;
               end else if (!best_valid_ff || cmp.p_better) begin
                  best_valid_in = 1'b1;
                  res_idx_in    = mid_ff;
                  res_t_in      = rd_time;
                  res_p_in      = rd_price;
               end
            end
            if (scan_stop || (!pend_ff && (idx_ff == count_ff))) begin
               res_status_in = best_valid_ff ? ST_OK : ST_NOT_FOUND;
               pend_in       = 1'b0;
               state_in      = S_EMIT;
            end else if (idx_ff != count_ff) begin
               pend_in = 1'b1;
               mid_in  = idx_ff[IDXW-1:0];
               idx_in  = idx_ff + CNTW'(1);
            end else begin
               pend_in = 1'b0;
            end
         end

         // hand the result to the output register once it is free
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_idx_in    = res_idx_ff;
               rsp_t_in      = res_t_ff;
               rsp_p_in      = res_p_ff;
               rsp_cnt_in    = count_ff;
               rsp_lp_in     = min_p_ff;
               rsp_lt_in     = min_t_ff;
               rsp_hp_in     = max_p_ff;
               rsp_ht_in     = max_t_ff;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_valid_ff  <= 1'b0;
         count_ff      <= '0;
         min_p_ff      <= '0;
         min_t_ff      <= '0;
         max_p_ff      <= '0;
         max_t_ff      <= '0;
         pend_ff       <= 1'b0;
         best_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         count_ff      <= count_in;
         min_p_ff      <= min_p_in;
         min_t_ff      <= min_t_in;
         max_p_ff      <= max_p_in;
         max_t_ff      <= max_t_in;
         pend_ff       <= pend_in;
         best_valid_ff <= best_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      ta_ff         <= ta_in;
      tb_ff         <= tb_in;
      pr_ff         <= pr_in;
      lo_ff         <= lo_in;
      hi_ex_ff      <= hi_ex_in;
      mid_ff        <= mid_in;
      idx_ff        <= idx_in;
      cand_t_ff     <= cand_t_in;
      cand_p_ff     <= cand_p_in;
      res_status_ff <= res_status_in;
      res_idx_ff    <= res_idx_in;
      res_t_ff      <= res_t_in;
      res_p_ff      <= res_p_in;
      rsp_status_ff <= rsp_status_in;
      rsp_idx_ff    <= rsp_idx_in;
      rsp_t_ff      <= rsp_t_in;
      rsp_p_ff      <= rsp_p_in;
      rsp_cnt_ff    <= rsp_cnt_in;
      rsp_lp_ff     <= rsp_lp_in;
      rsp_lt_ff     <= rsp_lt_in;
      rsp_hp_ff     <= rsp_hp_in;
      rsp_ht_ff     <= rsp_ht_in;
   end

endmodule : time_sorted_tick_store_search

`default_nettype wire

// ----- hdl/tsts_store.sv -----
`default_nettype none

// Tick store: one write port, one read port with registered read data.
module tsts_store
   #(parameter int DEPTH      = 4096,
     parameter int IDXW       = 12,
     parameter int TIME_BITS  = 48,
     parameter int PRICE_BITS = 32)
   (input  wire                          clock,
    input  wire                          wr_en,
    input  wire        [IDXW-1:0]        wr_addr,
    input  wire        [TIME_BITS-1:0]   wr_time,
    input  wire signed [PRICE_BITS-1:0]  wr_price,
    input  wire        [IDXW-1:0]        rd_addr,
    output logic       [TIME_BITS-1:0]   rd_time,
    output logic signed [PRICE_BITS-1:0] rd_price);

   logic        [TIME_BITS-1:0]  time_mem  [DEPTH];
   logic signed [PRICE_BITS-1:0] price_mem [DEPTH];

   logic        [TIME_BITS-1:0]  rd_time_ff;
   logic signed [PRICE_BITS-1:0] rd_price_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         time_mem[wr_addr]  <= wr_time;
         price_mem[wr_addr] <= wr_price;
      end
   end

   // read port, data in the cycle after the address
   always_ff @(posedge clock) begin
      rd_time_ff  <= time_mem[rd_addr];
      rd_price_ff <= price_mem[rd_addr];
   end

   assign rd_time  = rd_time_ff;
   assign rd_price = rd_price_ff;

endmodule : tsts_store

`default_nettype wire

// ----- hdl/tsts_cmp.sv -----
`default_nettype none

// Shared compare unit: one time sample against the two keys, one price pair.
module tsts_cmp
   import tsts_pkg::*;
   #(parameter int TIME_BITS  = 48,
     parameter int PRICE_BITS = 32)
   (input  wire        [TIME_BITS-1:0]  sample_time,
    input  wire        [TIME_BITS-1:0]  key_a,
    input  wire        [TIME_BITS-1:0]  key_b,
    input  wire signed [PRICE_BITS-1:0] new_price,
    input  wire signed [PRICE_BITS-1:0] best_price,
    input  wire                         want_max,
    output cmp_res_type                 res);

   always_comb begin
      res.t_eq     = (sample_time == key_a);
      res.t_lt_a   = (sample_time <  key_a);
      res.t_gt_a   = (sample_time >  key_a);
      res.t_gt_b   = (sample_time >  key_b);
      // strict, so ties keep the earlier tick
      res.p_better = want_max ? (new_price > best_price) : (new_price < best_price);
   end

endmodule : tsts_cmp

`default_nettype wire

// ----- hdl/tsts_checker.sv -----
`default_nettype none

// Port-level checks for the tick store.
module tsts_checker
   import tsts_pkg::*;
   #(parameter int STORE_DEPTH = 4096,
     parameter int TIME_BITS   = 48,
     parameter int PRICE_BITS  = 32,
     localparam int IDXW     = $clog2(STORE_DEPTH),
     localparam int CNTW     = $clog2(STORE_DEPTH + 1),
     localparam int RSP_BITS = IDXW + CNTW + 3 * TIME_BITS + 3 * PRICE_BITS,
     localparam int RSP_W    = ((RSP_BITS + 7) / 8) * 8)
   (input wire                   clock,
    input wire                   reset,
    input wire                   req_tvalid,
    input wire                   req_tready,
    input wire                   rsp_tvalid,
    input wire                   rsp_tready,
    input wire [RSP_W-1:0]       rsp_tdata,
    input wire [STATUS_BITS-1:0] rsp_tuser);

   // a stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   // a stalled result keeps its contents
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // an accepted item keeps the block busy for at least the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input ready right after an accepted item");

   // a new result only comes out of a busy cycle
   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("result appeared while the block was idle");

endmodule : tsts_checker

bind time_sorted_tick_store_search tsts_checker #(
   .STORE_DEPTH (STORE_DEPTH),
   .TIME_BITS   (TIME_BITS),
   .PRICE_BITS  (PRICE_BITS)
) u_tsts_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire

// ----- verif/time_sorted_tick_store_search_tb.sv -----
module time_sorted_tick_store_search_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import tsts_pkg::*;

   localparam int STORE_DEPTH   = 4096;
   localparam int REQ_W         = 128;
   localparam int RSP_W         = 272;
   localparam int RSP_USED      = 265;
   localparam int RANDOM_ITEMS  = 1650;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int REPORT_LINES  = 100;
   localparam logic [47:0] TIME_MAX         = 48'hFFFF_FFFF_FFFF;
   localparam logic signed [31:0] PRICE_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] PRICE_MAX = 32'sh7FFF_FFFF;

   // result item, status on top, then the rsp_tdata fields from the highest down
   typedef struct packed {
      status_type         status;
      logic [47:0]        high_time;
      logic signed [31:0] high_price;
      logic [47:0]        low_time;
      logic signed [31:0] low_price;
      logic [12:0]        entry_count;
      logic signed [31:0] hit_price;
      logic [47:0]        hit_time;
      logic [11:0]        hit_index;
   } tick_result_type;

   // tick store predictor and result checker
   class tick_store_scoreboard;
      logic [47:0]        time_mem [STORE_DEPTH];
      logic signed [31:0] price_mem [STORE_DEPTH];
      int                 fill;
      logic signed [31:0] lo_price, hi_price;
      logic [47:0]        lo_time, hi_time;
      tick_result_type    expected_tick_results [$];
      int                 mismatches;
      int                 results_seen;

      function new();
         fill = 0;
         lo_price = '0;
         hi_price = '0;
         lo_time = '0;
         hi_time = '0;
         mismatches = 0;
         results_seen = 0;
      endfunction

      // bisection over [0, fill-1]; -1 when nothing matches
      function int find_by_time(logic [47:0] key, op_type op);
         int lo, hi, mid;
         lo = 0;
         hi = fill - 1;
         while (hi >= lo) begin
            mid = (lo + hi) / 2;
            case (op)
               OP_EXACT: begin
                  if (time_mem[mid] == key) return mid;
                  if (time_mem[mid] > key) hi = mid - 1; else lo = mid + 1;
               end
               OP_NEXT: begin
                  if (time_mem[mid] >= key && (mid == 0 || time_mem[mid-1] < key)) return mid;
                  if (time_mem[mid] < key) lo = mid + 1; else hi = mid - 1;
               end
               default: begin
                  if (time_mem[mid] <= key && (mid == fill - 1 || time_mem[mid+1] > key))
                     return mid;
                  if (time_mem[mid] > key) hi = mid - 1; else lo = mid + 1;
               end
            endcase
         end
         return -1;
      endfunction

      // linear walk from index 0, first strict extreme wins
      function int scan_range(logic [47:0] ta, logic [47:0] tb, bit want_max);
         int best;
         best = -1;
         for (int i = 0; i < fill; i++) begin
            if (time_mem[i] < ta) continue;
            if (time_mem[i] > tb) break;
            if (best < 0)
               best = i;
            else if (want_max ? (price_mem[i] > price_mem[best])
                              : (price_mem[i] < price_mem[best]))
               best = i;
         end
         return best;
      endfunction

      function tick_result_type apply_tick_op(op_type op, logic [47:0] ta, logic [47:0] tb,
                                              logic signed [31:0] pr);
         tick_result_type r;
         int hit;
         r = '0;
         hit = -1;
         r.status = ST_OK;
         case (op)
            OP_APPEND: begin
               if (fill >= STORE_DEPTH) begin
                  r.status = ST_FULL;
               end else begin
                  time_mem[fill] = ta;
                  price_mem[fill] = pr;
                  if (fill == 0) begin
                     lo_price = pr; lo_time = ta;
                     hi_price = pr; hi_time = ta;
                  end else begin
                     if (pr < lo_price) begin lo_price = pr; lo_time = ta; end
                     if (pr > hi_price) begin hi_price = pr; hi_time = ta; end
                  end
                  hit = fill;
                  fill++;
               end
            end
            OP_CLEAR: begin
               fill = 0;
               lo_price = '0; lo_time = '0;
               hi_price = '0; hi_time = '0;
            end
            OP_EXACT, OP_NEXT, OP_PREV, OP_RANGE_MAX, OP_RANGE_MIN: begin
               if (fill == 0) begin
                  r.status = ST_EMPTY;
               end else begin
                  if (op == OP_RANGE_MAX || op == OP_RANGE_MIN)
                     hit = scan_range(ta, tb, op == OP_RANGE_MAX);
                  else
                     hit = find_by_time(ta, op);
                  if (hit < 0) r.status = ST_NOT_FOUND;
               end
            end
            default: ;
         endcase
         if (hit >= 0) begin
            r.hit_index = hit[11:0];
            r.hit_time  = time_mem[hit];
            r.hit_price = price_mem[hit];
         end
         r.entry_count = fill[12:0];
         r.low_price   = lo_price;
         r.low_time    = lo_time;
         r.high_price  = hi_price;
         r.high_time   = hi_time;
         return r;
      endfunction

      function void note_request(op_type op, logic [47:0] ta, logic [47:0] tb,
                                 logic signed [31:0] pr);
         expected_tick_results.push_back(apply_tick_op(op, ta, tb, pr));
      endfunction

      task report_mismatch(string msg);
         if (mismatches < REPORT_LINES) $display("result %0d: %s", results_seen, msg);
         mismatches++;
      endtask

      task compare_field(string name, logic [63:0] got, logic [63:0] want);
         if (got !== want)
            report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
      endtask

      task check_result(logic [RSP_W-1:0] data, logic [STATUS_BITS-1:0] status);
         tick_result_type got, want;
         results_seen++;
         if (expected_tick_results.size() == 0) begin
            report_mismatch("result item with no request outstanding");
            return;
         end
         want = expected_tick_results.pop_front();
         got = {status, data[RSP_USED-1:0]};
         compare_field("status", got.status, want.status);
         compare_field("hit_index", got.hit_index, want.hit_index);
         compare_field("hit_time", got.hit_time, want.hit_time);
         compare_field("hit_price", got.hit_price, want.hit_price);
         compare_field("entry_count", got.entry_count, want.entry_count);
         compare_field("low_price", got.low_price, want.low_price);
         compare_field("low_time", got.low_time, want.low_time);
         compare_field("high_price", got.high_price, want.high_price);
         compare_field("high_time", got.high_time, want.high_time);
         compare_field("padding", data[RSP_W-1:RSP_USED], '0);
      endtask
   endclass

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_W-1:0]       req_tdata;   // time_a, time_b, tick_price
   logic [OP_BITS-1:0]     req_tuser;   // opcode
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_W-1:0]       rsp_tdata;   // hit_index, hit_time, hit_price, entry_count,
                                        // low_price, low_time, high_price, high_time
   logic [STATUS_BITS-1:0] rsp_tuser;   // status

   tick_store_scoreboard sb;
   bit                   steady_flow;
   int unsigned          cycle_count = 0;
   logic [47:0]          last_time;

   time_sorted_tick_store_search i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser));

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   function automatic logic [47:0] rand48();
      logic [63:0] w;
      w = {$urandom(), $urandom()};
      return w[47:0];
   endfunction

   function automatic logic signed [31:0] rand_price();
      case ($urandom_range(0, 7))
         0: return PRICE_MIN;
         1: return PRICE_MAX;
         2, 3: return $signed($urandom_range(0, 16)) - 8;
         default: return $urandom();
      endcase
   endfunction

   // step forward in time, pinned at the top of the range
   function automatic logic [47:0] advance(logic [47:0] t, logic [47:0] step);
      return (t > TIME_MAX - step) ? TIME_MAX : t + step;
   endfunction

   // search key: mostly a stored timestamp or its neighbor
   function automatic logic [47:0] pick_key();
      logic [47:0] k;
      if (sb.fill != 0 && $urandom_range(0, 3) != 0) begin
         k = sb.time_mem[$urandom_range(0, sb.fill - 1)];
         case ($urandom_range(0, 3))
            0: k = k - 1;
            1: k = k + 1;
            default: ;
         endcase
      end else begin
         k = rand48();
      end
      return k;
   endfunction

   // one request item; tvalid stays high when the next item follows at once
   task automatic send_item(op_type op, logic [47:0] ta, logic [47:0] tb,
                            logic signed [31:0] pr);
      int gap;
      gap = steady_flow ? 0 : $urandom_range(0, 10);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {pr, tb, ta};
      @(posedge clock);
      while (req_tready !== 1'b1) @(posedge clock);
      sb.note_request(op, ta, tb, pr);
   endtask

   // hold off until every outstanding result is back
   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      while (sb.expected_tick_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic append_tick(logic [47:0] t, logic signed [31:0] pr);
      send_item(OP_APPEND, t, rand48(), pr);
   endtask

   task automatic run_directed();
      // empty store
      send_item(OP_EXACT, 48'd5, rand48(), rand_price());
      send_item(OP_RANGE_MAX, 48'd0, TIME_MAX, rand_price());
      send_item(OP_NOP, rand48(), rand48(), rand_price());
      // ties on both extremes, duplicate time, both time extremes
      append_tick(48'd0, PRICE_MIN);
      append_tick(48'd5, PRICE_MAX);
      append_tick(48'd5, 32'sd7);
      append_tick(48'd9, PRICE_MAX);
      append_tick(TIME_MAX, PRICE_MIN);
      send_item(OP_EXACT, 48'd5, rand48(), rand_price());
      send_item(OP_EXACT, 48'd6, rand48(), rand_price());
      send_item(OP_NEXT, 48'd6, rand48(), rand_price());
      send_item(OP_NEXT, 48'd0, rand48(), rand_price());
      send_item(OP_NEXT, TIME_MAX, rand48(), rand_price());
      send_item(OP_PREV, 48'd4, rand48(), rand_price());
      send_item(OP_PREV, TIME_MAX, rand48(), rand_price());
      send_item(OP_PREV, 48'd5, rand48(), rand_price());
      send_item(OP_RANGE_MAX, 48'd0, TIME_MAX, rand_price());
      send_item(OP_RANGE_MIN, 48'd5, 48'd9, rand_price());
      // start after end, and a window with no entries
      send_item(OP_RANGE_MAX, 48'd9, 48'd5, rand_price());
      send_item(OP_RANGE_MIN, 48'd6, 48'd8, rand_price());
      send_item(OP_NOP, rand48(), rand48(), rand_price());
      send_item(OP_CLEAR, rand48(), rand48(), rand_price());
      send_item(OP_PREV, 48'd5, rand48(), rand_price());
   endtask

   task automatic run_random();
      int roll;
      logic [47:0] ta, tb, swap;
      op_type op;
      last_time = rand48();
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 150 == 0) steady_flow = ($urandom_range(0, 3) == 0);
         if (n % 400 == 399) wait_for_drain();
         roll = $urandom_range(0, 99);
         if ((sb.fill >= 80 && roll < 50) || roll < 3) begin
            send_item(OP_CLEAR, rand48(), rand48(), rand_price());
            // new time base: bottom, top or anywhere
            case ($urandom_range(0, 3))
               0: last_time = '0;
               1: last_time = TIME_MAX - $urandom_range(0, 200);
               default: last_time = rand48();
            endcase
         end else if (roll < 45) begin
            case ($urandom_range(0, 19))
               0: ta = rand48();
               1, 2, 3: ta = last_time;
               4: ta = advance(last_time, {16'd0, $urandom()});
               default: ta = advance(last_time, $urandom_range(1, 5));
            endcase
            last_time = ta;
            append_tick(ta, rand_price());
         end else if (roll < 48) begin
            send_item(OP_NOP, rand48(), rand48(), rand_price());
         end else begin
            op = op_type'($urandom_range(int'(OP_EXACT), int'(OP_RANGE_MIN)));
            ta = pick_key();
            tb = rand48();
            if (op == OP_RANGE_MAX || op == OP_RANGE_MIN) begin
               tb = pick_key();
               if (ta > tb && $urandom_range(0, 3) != 0) begin
                  swap = ta; ta = tb; tb = swap;
               end
            end
            send_item(op, ta, tb, rand_price());
         end
      end
   endtask

   // stimulus
   initial begin
      sb = new();
      steady_flow = 1'b0;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= OP_NOP;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      wait_for_drain();
      run_random();
      wait_for_drain();
      repeat (40) @(posedge clock);
      if (sb.mismatches == 0 && sb.expected_tick_results.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   // result side with random backpressure
   initial begin : result_sink
      int stall;
      rsp_tready <= 1'b0;
      @(posedge clock);
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         stall = steady_flow ? 0 : $urandom_range(0, 10);
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (rsp_tvalid !== 1'b1) @(posedge clock);
         sb.check_result(rsp_tdata, rsp_tuser);
      end
   end

endmodule

// ----- time_sorted_tick_store_search.f -----
hdl/tsts_pkg.sv
hdl/tsts_store.sv
hdl/tsts_cmp.sv
hdl/time_sorted_tick_store_search.sv
hdl/tsts_checker.sv
verif/time_sorted_tick_store_search_tb.sv
